@@ rtl/dcf_pkg.sv @@
// Shared types and constants for the delayed coincidence filter.
// No dependencies; imported by every module of the block.
package dcf_pkg;

  localparam int NUM_COMPONENTS = 16;

  localparam int TIME_W     = 48;
  localparam int INTERVAL_W = 32;
  localparam int POS_W      = 24;
  localparam int SQ_W       = 2 * POS_W;
  localparam int DSUM_W     = SQ_W + 2;
  localparam int COMP_W     = 4;
  localparam int MASK_W     = 16;
  localparam int FILE_W     = 16;
  localparam int EVENT_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DWIN_W     = 24;

  localparam logic [INTERVAL_W-1:0] TIME_WIN_RST        = 32'd1000;
  localparam logic [DWIN_W-1:0]     DISTANCE_WINDOW_RST = 24'd1000;
  localparam logic [MASK_W-1:0]     SINGLE_MASK_RST     = 16'hFFFF;

  typedef logic [POS_W-1:0]  pos_t;
  typedef pos_t [2:0]        pos3_t;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef sq_t [2:0]         sq3_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_WIN        = 2'd0,
    CFG_DISTANCE_WINDOW = 2'd1,
    CFG_SINGLE_MASK     = 2'd2
  } cfg_reg_t;

endpackage

@@ rtl/dcf_sqdist.sv @@
// Per-axis squared distance between two positions.
// Depends on dcf_pkg for the position and square types.
module dcf_sqdist (
  input  dcf_pkg::pos3_t pos_a,
  input  dcf_pkg::pos3_t pos_b,
  output dcf_pkg::sq3_t  sq
);
  import dcf_pkg::*;

  always_comb begin
    logic signed [POS_W:0] diff;
    logic [POS_W:0]        mag;
    for (int i = 0; i < 3; i++) begin
      diff = $signed({pos_a[i][POS_W-1], pos_a[i]}) - $signed({pos_b[i][POS_W-1], pos_b[i]});
      mag  = diff[POS_W] ? (~diff + 1'b1) : diff;
      // magnitude never exceeds 2^POS_W - 1, so the top bit is always clear
      sq[i] = SQ_W'(mag[POS_W-1:0]) * SQ_W'(mag[POS_W-1:0]);
    end
  end

endmodule

@@ rtl/delayed_coincidence_filter_unit.sv @@
// Delayed coincidence filter: top level with input, square and decision stages.
// Depends on dcf_pkg and dcf_sqdist.
//
// Usage:
//   Input channel (in_*) carries one detector event per beat: the interval
//   since the previous event, its component, position and file/event index.
//   Result channel (out_*) carries the previous (held) event when it is kept:
//   it has a partner within the time and distance windows before or after it,
//   or its component is not marked single in single_mask.
//   Configuration channel (cfg_*) writes the time window, the distance window
//   and single_mask by index; cfg_ready is always high. Write only while idle.
// Timing:
//   One event per cycle unless the output stalls. A deciding event moves from
//   the input register to the squared-distance register, and the decision on
//   the held event lands in the output register. The squared distances need
//   one 24x24 multiplier per axis, then a three-term add and compare.
// Reset:
//   Synchronous, active low. Clears the running time and history; the first
//   event after reset only becomes the held event and produces no result.
// Back-pressure:
//   With out_ready low the output register holds its beat; the decision and
//   input stages fill behind it and in_ready drops until the result is taken.
module delayed_coincidence_filter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dcf_pkg::INTERVAL_W-1:0]    in_interval_ns,
  input  logic [dcf_pkg::COMP_W-1:0]        in_component,
  input  logic signed [dcf_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [dcf_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [dcf_pkg::POS_W-1:0]  in_pos_z,
  input  logic [dcf_pkg::FILE_W-1:0]        in_file_index,
  input  logic [dcf_pkg::EVENT_W-1:0]       in_event_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dcf_pkg::TIME_W-1:0]        out_kept_time,
  output logic [dcf_pkg::COMP_W-1:0]        out_kept_component,
  output logic [dcf_pkg::FILE_W-1:0]        out_kept_file,
  output logic [dcf_pkg::EVENT_W-1:0]       out_kept_event,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dcf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dcf_pkg::*;

  // configuration
  logic [INTERVAL_W-1:0] tw_r;
  logic [DWIN_W-1:0]     dw_r;
  logic [MASK_W-1:0]     mask_r;
  logic [SQ_W-1:0]       win_sq_r;

  // input stage
  logic                  s1_v_r;
  logic [INTERVAL_W-1:0] s1_interval_r;
  logic [COMP_W-1:0]     s1_comp_r;
  pos3_t                 s1_pos_r;
  logic [FILE_W-1:0]     s1_file_r;
  logic [EVENT_W-1:0]    s1_event_r;

  // held event and running time
  logic [TIME_W-1:0]     time_r;
  pos3_t                 held_pos_r;
  logic [COMP_W-1:0]     held_comp_r;
  logic [FILE_W-1:0]     held_file_r;
  logic [EVENT_W-1:0]    held_event_r;

  // decision stage
  logic                  s2_v_r;
  sq3_t                  s2_sq_r;
  logic [INTERVAL_W-1:0] s2_interval_r;
  logic [TIME_W-1:0]     s2_time_r;
  logic [COMP_W-1:0]     s2_comp_r;
  logic [FILE_W-1:0]     s2_file_r;
  logic [EVENT_W-1:0]    s2_event_r;
  logic [1:0]            hist_r;
  logic [1:0]            hist_nxt;
  logic [DSUM_W-1:0]     prev_dist_r;
  logic [INTERVAL_W-1:0] prev_int_r;

  // output register
  logic                  out_v_r;
  logic [TIME_W-1:0]     out_time_r;
  logic [COMP_W-1:0]     out_comp_r;
  logic [FILE_W-1:0]     out_file_r;
  logic [EVENT_W-1:0]    out_event_r;

  logic                  s2_adv;
  logic                  s2_take;
  logic                  s1_adv;
  sq3_t                  sq_fwd;
  logic [DSUM_W-1:0]     dist_fwd;
  logic                  fwd_hit;
  logic                  back_hit;
  logic                  single;
  logic                  keep;

  assign s2_adv   = s2_v_r && (!out_v_r || out_ready);
  assign s2_take  = !s2_v_r || s2_adv;
  assign s1_adv   = s1_v_r && s2_take;
  assign in_ready = !s1_v_r || s1_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r   <= TIME_WIN_RST;
      dw_r   <= DISTANCE_WINDOW_RST;
      mask_r <= SINGLE_MASK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TIME_WIN:        tw_r   <= cfg_data[INTERVAL_W-1:0];
        CFG_DISTANCE_WINDOW: dw_r   <= cfg_data[DWIN_W-1:0];
        CFG_SINGLE_MASK:     mask_r <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    win_sq_r <= SQ_W'(dw_r) * SQ_W'(dw_r);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_interval_r <= in_interval_ns;
      s1_comp_r     <= in_component;
      s1_pos_r      <= {in_pos_z, in_pos_y, in_pos_x};
      s1_file_r     <= in_file_index;
      s1_event_r    <= in_event_index;
    end
  end

  dcf_sqdist u_sqdist (
    .pos_a (s1_pos_r),
    .pos_b (held_pos_r),
    .sq    (sq_fwd)
  );

  // advance running time; new event becomes the held one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (s1_adv) begin
      time_r <= time_r + TIME_W'(s1_interval_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      held_pos_r    <= s1_pos_r;
      held_comp_r   <= s1_comp_r;
      held_file_r   <= s1_file_r;
      held_event_r  <= s1_event_r;
      s2_sq_r       <= sq_fwd;
      s2_interval_r <= s1_interval_r;
      s2_time_r     <= time_r;
      s2_comp_r     <= held_comp_r;
      s2_file_r     <= held_file_r;
      s2_event_r    <= held_event_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_take) begin
      s2_v_r <= s1_v_r;
    end
  end

  // decision on the held event
  assign dist_fwd = DSUM_W'(s2_sq_r[0]) + DSUM_W'(s2_sq_r[1]) + DSUM_W'(s2_sq_r[2]);
  assign fwd_hit  = (s2_interval_r < tw_r) && (dist_fwd < DSUM_W'(win_sq_r));
  assign back_hit = hist_r[1] && (prev_int_r < tw_r) && (prev_dist_r < DSUM_W'(win_sq_r));
  assign single   = (int'(s2_comp_r) >= NUM_COMPONENTS) || mask_r[s2_comp_r];
  assign keep     = (hist_r != 2'd0) && (back_hit || fwd_hit || !single);
  assign hist_nxt = hist_r[1] ? hist_r : hist_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= 2'd0;
    end else if (s2_adv) begin
      hist_r <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      prev_dist_r <= dist_fwd;
      prev_int_r  <= s2_interval_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_adv) begin
      out_v_r <= keep;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && keep) begin
      out_time_r  <= s2_time_r;
      out_comp_r  <= s2_comp_r;
      out_file_r  <= s2_file_r;
      out_event_r <= s2_event_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_kept_time      = out_time_r;
  assign out_kept_component = out_comp_r;
  assign out_kept_file      = out_file_r;
  assign out_kept_event     = out_event_r;

endmodule

@@ rtl/dcf_checker.sv @@
// Port-level checks for the delayed coincidence filter, bound to the top level.
// Depends on dcf_pkg and delayed_coincidence_filter_unit.
module dcf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [dcf_pkg::TIME_W-1:0]        out_kept_time,
  input logic [dcf_pkg::COMP_W-1:0]        out_kept_component,
  input logic [dcf_pkg::FILE_W-1:0]        out_kept_file,
  input logic [dcf_pkg::EVENT_W-1:0]       out_kept_event,
  input logic                              cfg_ready
);
  import dcf_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kept_time) &&
      $stable(out_kept_component) && $stable(out_kept_file) && $stable(out_kept_event))
    else $error("result beat changed while stalled");

  // input back-pressure only comes from a stalled output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> cfg_ready)
    else $error("config port blocked while input stalled");

endmodule

bind delayed_coincidence_filter_unit dcf_checker u_dcf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_kept_time      (out_kept_time),
  .out_kept_component (out_kept_component),
  .out_kept_file      (out_kept_file),
  .out_kept_event     (out_kept_event),
  .cfg_ready          (cfg_ready)
);
